// ----- src/gcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcw_pkg: shared types and constants of the grapheme cluster segmenter
// Character classes, Hangul kinds, width codes, the input word and the
// cluster state that travels between the step logic and the top level.
// ----------------------------------------------------------------------------
package gcw_pkg;

   localparam int MAX_CLUSTER_DEF = 16;

   localparam int CP_W    = 21;
   localparam int CLASS_W = 3;
   localparam int HK_W    = 3;
   localparam int WC_W    = 3;

   // character classes
   localparam logic [CLASS_W-1:0] CLS_OTHER     = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_COMBINING = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_PICTO     = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_EMOJI_MOD = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_TEXT_MOD  = 3'd4;
   localparam logic [CLASS_W-1:0] CLS_REGIONAL  = 3'd5;
   localparam logic [CLASS_W-1:0] CLS_HANGUL    = 3'd6;

   // Hangul kinds
   localparam logic [HK_W-1:0] HK_NONE = 3'd0;
   localparam logic [HK_W-1:0] HK_L    = 3'd1;
   localparam logic [HK_W-1:0] HK_V    = 3'd2;
   localparam logic [HK_W-1:0] HK_T    = 3'd3;
   localparam logic [HK_W-1:0] HK_LV   = 3'd4;
   localparam logic [HK_W-1:0] HK_LVT  = 3'd5;

   // cluster flag bits
   localparam logic [1:0] FLAG_NONE  = 2'b00;
   localparam logic [1:0] FLAG_EMOJI = 2'b01;
   localparam logic [1:0] FLAG_WIDE  = 2'b10;
   localparam logic [1:0] FLAG_ALL   = 2'b11;

   // width codes
   localparam logic signed [WC_W-1:0] WC_JOIN   = 3'sd0;
   localparam logic signed [WC_W-1:0] WC_NARROW = 3'sd1;
   localparam logic signed [WC_W-1:0] WC_WIDE   = 3'sd2;
   localparam logic signed [WC_W-1:0] WC_WIDEN  = -3'sd2;

   typedef struct packed {
      logic [CP_W-1:0]    codepoint;
      logic [CLASS_W-1:0] base_class;
      logic               is_zwj;
      logic               is_skin_tone;
      logic [HK_W-1:0]    hangul_kind;
      logic               emoji_char;
      logic               double_width;
      logic               restart;
   } item_type;

   typedef struct packed {
      logic               picto_sequence;
      logic               last_zwj;
      logic [CLASS_W-1:0] last_base_class;
      logic [1:0]         cluster_flags;
      logic [HK_W-1:0]    tail_hangul_kind;
   } state_type;

   localparam state_type STATE_RESET = '{
      picto_sequence:   1'b0,
      last_zwj:         1'b0,
      last_base_class:  CLS_OTHER,
      cluster_flags:    FLAG_NONE,
      tail_hangul_kind: HK_NONE
   };

   function automatic logic hangul_joins(input logic [HK_W-1:0] prev,
                                         input logic [HK_W-1:0] cur);
      logic res;
      res = 1'b0;
      case (prev)
         HK_L:         res = (cur == HK_L) || (cur == HK_V) || (cur == HK_LV) ||
                             (cur == HK_LVT);
         HK_V, HK_LV:  res = (cur == HK_V) || (cur == HK_T);
         HK_T, HK_LVT: res = (cur == HK_T);
         default:      res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ----- src/gcw_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcw_step: join decision for one codepoint
// Combinational: from the registered word and the cluster state, decide
// join or new cluster, and form the next state and the result word.
// ----------------------------------------------------------------------------
module gcw_step #(
   parameter int MAX_CLUSTER = gcw_pkg::MAX_CLUSTER_DEF,
   parameter int CNT_W       = $clog2(MAX_CLUSTER + 1)
) (
   input  gcw_pkg::item_type                  item,
   input  gcw_pkg::state_type                 st,
   input  logic [CNT_W-1:0]                   cnt,
   output gcw_pkg::state_type                 st_next,
   output logic [CNT_W-1:0]                   cnt_next,
   output logic signed [gcw_pkg::WC_W-1:0]    width_code,
   output logic [CNT_W-1:0]                   slot
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLUSTER);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic       join_w;
   logic [1:0] pflags;

   assign pflags = {item.double_width, item.emoji_char};

   always_comb begin
      join_w     = 1'b0;
      width_code = gcw_pkg::WC_JOIN;
      st_next    = st;
      cnt_next   = cnt;
      slot       = '0;

      if (cnt != '0 && !item.restart) begin
         case (item.base_class)
            gcw_pkg::CLS_EMOJI_MOD: begin
               // skin tones attach only to a pictograph
               if (!item.is_skin_tone || st.last_base_class == gcw_pkg::CLS_PICTO) begin
                  if (st.cluster_flags == gcw_pkg::FLAG_NONE) begin
                     width_code = gcw_pkg::WC_WIDEN;
                  end
                  st_next.cluster_flags = gcw_pkg::FLAG_ALL;
                  join_w = 1'b1;
               end
            end
            gcw_pkg::CLS_TEXT_MOD: begin
               st_next.picto_sequence = 1'b0;
               st_next.cluster_flags  = st.cluster_flags & ~gcw_pkg::FLAG_EMOJI;
               join_w = 1'b1;
            end
            gcw_pkg::CLS_PICTO: begin
               join_w = st.picto_sequence && st.last_zwj;
            end
            gcw_pkg::CLS_REGIONAL: begin
               join_w = (st.last_base_class == gcw_pkg::CLS_REGIONAL) && (cnt == CNT_ONE);
            end
            gcw_pkg::CLS_HANGUL: begin
               join_w = gcw_pkg::hangul_joins(st.tail_hangul_kind, item.hangul_kind);
            end
            gcw_pkg::CLS_COMBINING: begin
               join_w = 1'b1;
            end
            default: begin
               join_w = 1'b0;
            end
         endcase
      end

      if (join_w) begin
         slot = cnt;
         // saturated cluster: hold count and Hangul tail
         if (cnt < CNT_MAX) begin
            st_next.tail_hangul_kind = item.hangul_kind;
            cnt_next = cnt + CNT_ONE;
         end
      end else begin
         st_next.picto_sequence   = (item.base_class == gcw_pkg::CLS_PICTO);
         st_next.cluster_flags    = pflags;
         st_next.tail_hangul_kind = item.hangul_kind;
         cnt_next   = CNT_ONE;
         width_code = (pflags != gcw_pkg::FLAG_NONE) ? gcw_pkg::WC_WIDE : gcw_pkg::WC_NARROW;
      end

      st_next.last_zwj        = item.is_zwj;
      st_next.last_base_class = item.base_class;
   end

endmodule

// ----- src/grapheme_cluster_width_segmenter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grapheme_cluster_width_segmenter: grapheme clustering with cell widths
// Input register, single-pass join logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one codepoint word with its class and lookup flags.
//   A word is taken on a rising edge with req_valid high and req_stall low.
//   rsp_* carries one result word per input word, in order: width code,
//   cluster flags, store slot, the codepoint and the cluster length.
//   An accepted word passes the input register, then the result register,
//   which it enters once that register is free. Throughput is one word per
//   cycle while rsp_stall is low; the cluster state is updated in the same
//   cycle a word enters the result register, so words chain without bubbles.
//   When the receiver holds rsp_stall, the result word holds, the input
//   register fills, and req_stall rises once the input register holds a word.
//   Reset (synchronous, active high) empties both registers and clears the
//   cluster state to an empty cluster; the first word then starts a cluster.
//   store_slot and cluster_length are $clog2(MAX_CLUSTER+1) bits wide and
//   the cluster length saturates at MAX_CLUSTER.
// ----------------------------------------------------------------------------
module grapheme_cluster_width_segmenter #(
   parameter int MAX_CLUSTER = gcw_pkg::MAX_CLUSTER_DEF,
   parameter int CNT_W       = $clog2(MAX_CLUSTER + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gcw_pkg::CP_W-1:0]          req_codepoint,
   input  logic [gcw_pkg::CLASS_W-1:0]       req_base_class,
   input  logic                              req_is_zwj,
   input  logic                              req_is_skin_tone,
   input  logic [gcw_pkg::HK_W-1:0]          req_hangul_kind,
   input  logic                              req_emoji_char,
   input  logic                              req_double_width,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [gcw_pkg::WC_W-1:0]   rsp_width_code,
   output logic                              rsp_cluster_emoji,
   output logic                              rsp_cluster_wide,
   output logic [CNT_W-1:0]                  rsp_store_slot,
   output logic [gcw_pkg::CP_W-1:0]          rsp_stored_codepoint,
   output logic [CNT_W-1:0]                  rsp_cluster_length
);

   logic               in_v_ff;
   gcw_pkg::item_type  in_item_ff;
   gcw_pkg::state_type st_ff;
   gcw_pkg::state_type st_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;

   logic                           out_v_ff;
   logic signed [gcw_pkg::WC_W-1:0] wc_in;
   logic [CNT_W-1:0]               slot_in;
   logic signed [gcw_pkg::WC_W-1:0] wc_ff;
   logic [1:0]                     flags_ff;
   logic [CNT_W-1:0]               slot_ff;
   logic [gcw_pkg::CP_W-1:0]       cp_ff;
   logic [CNT_W-1:0]               len_ff;

   logic out_free;
   logic advance;
   logic req_take;

   assign out_free  = !out_v_ff || !rsp_stall;
   assign advance   = in_v_ff && out_free;
   assign req_stall = in_v_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   gcw_step #(
      .MAX_CLUSTER (MAX_CLUSTER),
      .CNT_W       (CNT_W)
   ) u_step (
      .item       (in_item_ff),
      .st         (st_ff),
      .cnt        (cnt_ff),
      .st_next    (st_in),
      .cnt_next   (cnt_in),
      .width_code (wc_in),
      .slot       (slot_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         st_ff    <= gcw_pkg::STATE_RESET;
         cnt_ff   <= '0;
      end else begin
         if (req_take) begin
            in_v_ff <= 1'b1;
         end else if (advance) begin
            in_v_ff <= 1'b0;
         end
         if (advance) begin
            out_v_ff <= 1'b1;
            st_ff    <= st_in;
            cnt_ff   <= cnt_in;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{
            codepoint:    req_codepoint,
            base_class:   req_base_class,
            is_zwj:       req_is_zwj,
            is_skin_tone: req_is_skin_tone,
            hangul_kind:  req_hangul_kind,
            emoji_char:   req_emoji_char,
            double_width: req_double_width,
            restart:      req_restart
         };
      end
      if (advance) begin
         wc_ff    <= wc_in;
         flags_ff <= st_in.cluster_flags;
         slot_ff  <= slot_in;
         cp_ff    <= in_item_ff.codepoint;
         len_ff   <= cnt_in;
      end
   end

   assign rsp_valid            = out_v_ff;
   assign rsp_width_code       = wc_ff;
   assign rsp_cluster_emoji    = flags_ff[0];
   assign rsp_cluster_wide     = flags_ff[1];
   assign rsp_store_slot       = slot_ff;
   assign rsp_stored_codepoint = cp_ff;
   assign rsp_cluster_length   = len_ff;

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_CLUSTER))
      else $error("cluster count above maximum");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cluster_length != '0))
      else $error("result with empty cluster");

   a_new_cluster: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_width_code == gcw_pkg::WC_NARROW ||
                    rsp_width_code == gcw_pkg::WC_WIDE)
      |-> (rsp_store_slot == '0) && (rsp_cluster_length == CNT_W'(1)))
      else $error("new cluster not at slot zero with length one");

   a_widen_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_width_code == gcw_pkg::WC_WIDEN)
      |-> rsp_cluster_emoji && rsp_cluster_wide)
      else $error("widen code without emoji and wide flags");

   a_join_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_width_code == gcw_pkg::WC_JOIN ||
                    rsp_width_code == gcw_pkg::WC_WIDEN)
      |-> (rsp_store_slot != '0))
      else $error("joined codepoint stored at slot zero");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for grapheme_cluster_width_segmenter
// Sends a directed table of codepoint words, then random well-formed
// emoji, Hangul, regional and combining sequences mixed with noise. Each
// accepted word runs through a cluster predictor. Result words are checked
// field by field, in order, against the expected cells. Both channels idle
// in random bursts, and the receiver holds off once long enough to
// back-pressure the input.
// ----------------------------------------------------------------------------
module tb;

   localparam int CP_W           = gcw_pkg::CP_W;
   localparam int CLASS_W        = gcw_pkg::CLASS_W;
   localparam int HK_W           = gcw_pkg::HK_W;
   localparam int WC_W           = gcw_pkg::WC_W;
   localparam int CLUSTER_CAP    = gcw_pkg::MAX_CLUSTER_DEF;
   localparam int CNT_W          = $clog2(CLUSTER_CAP + 1);
   localparam int DIR_ROWS       = 25;
   localparam int RANDOM_WORDS   = 1800;
   localparam int CALM_WORDS     = 150;
   localparam int PRESSURE_AT    = 400;
   localparam int PRESSURE_LEN   = 64;
   localparam int WATCHDOG_LIMIT = 2000;

   // class and kind codes outside the defined set
   localparam logic [CLASS_W-1:0] CLS_UNUSED  = 3'd7;
   localparam logic [HK_W-1:0]    HK_UNUSED_6 = 3'd6;
   localparam logic [HK_W-1:0]    HK_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic signed [WC_W-1:0] width_code;
      logic                   emoji;
      logic                   wide;
      logic [CNT_W-1:0]       slot;
      logic [CP_W-1:0]        cp;
      logic [CNT_W-1:0]       len;
   } cell_result_type;

   typedef struct packed {
      gcw_pkg::item_type word;
      logic              typed;
      cell_result_type   want;
   } dir_row_type;

   localparam cell_result_type NO_CELL = '0;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [CP_W-1:0]         req_codepoint;
   logic [CLASS_W-1:0]      req_base_class;
   logic                    req_is_zwj;
   logic                    req_is_skin_tone;
   logic [HK_W-1:0]         req_hangul_kind;
   logic                    req_emoji_char;
   logic                    req_double_width;
   logic                    req_restart;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [WC_W-1:0]  rsp_width_code;
   logic                    rsp_cluster_emoji;
   logic                    rsp_cluster_wide;
   logic [CNT_W-1:0]        rsp_store_slot;
   logic [CP_W-1:0]         rsp_stored_codepoint;
   logic [CNT_W-1:0]        rsp_cluster_length;

   // cluster predictor state
   logic                    cl_picto      = 1'b0;
   logic                    cl_after_zwj  = 1'b0;
   logic [CLASS_W-1:0]      cl_prev_class = gcw_pkg::CLS_OTHER;
   logic [1:0]              cl_flags      = gcw_pkg::FLAG_NONE;
   logic [CNT_W-1:0]        cl_len        = '0;
   logic [HK_W-1:0]         cl_tail_hk    = gcw_pkg::HK_NONE;

   cell_result_type         pending_cells[$];
   cell_result_type         seen;
   cell_result_type         due;
   int                      err_count    = 0;
   int                      quiet_cycles = 0;
   int                      words_sent   = 0;
   int                      req_idle_pct = 0;
   bit                      calm_tail    = 1'b0;

   grapheme_cluster_width_segmenter i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_codepoint        (req_codepoint),
      .req_base_class       (req_base_class),
      .req_is_zwj           (req_is_zwj),
      .req_is_skin_tone     (req_is_skin_tone),
      .req_hangul_kind      (req_hangul_kind),
      .req_emoji_char       (req_emoji_char),
      .req_double_width     (req_double_width),
      .req_restart          (req_restart),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_width_code       (rsp_width_code),
      .rsp_cluster_emoji    (rsp_cluster_emoji),
      .rsp_cluster_wide     (rsp_cluster_wide),
      .rsp_store_slot       (rsp_store_slot),
      .rsp_stored_codepoint (rsp_stored_codepoint),
      .rsp_cluster_length   (rsp_cluster_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic gcw_pkg::item_type mk_word(input logic [CP_W-1:0] cp,
                                                 input logic [CLASS_W-1:0] cls,
                                                 input logic zwj, input logic skin,
                                                 input logic [HK_W-1:0] hk,
                                                 input logic emo, input logic dw,
                                                 input logic rst);
      gcw_pkg::item_type w;
      w.codepoint    = cp;
      w.base_class   = cls;
      w.is_zwj       = zwj;
      w.is_skin_tone = skin;
      w.hangul_kind  = hk;
      w.emoji_char   = emo;
      w.double_width = dw;
      w.restart      = rst;
      return w;
   endfunction

   function automatic cell_result_type mk_cell(input logic signed [WC_W-1:0] code,
                                               input logic emo, input logic wide,
                                               input int slot,
                                               input logic [CP_W-1:0] cp,
                                               input int len);
      cell_result_type c;
      c.width_code = code;
      c.emoji      = emo;
      c.wide       = wide;
      c.slot       = slot[CNT_W-1:0];
      c.cp         = cp;
      c.len        = len[CNT_W-1:0];
      return c;
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [CP_W-1:0] rand_picto_cp();
      return CP_W'($urandom_range(21'h1F300, 21'h1FAFF));
   endfunction

   function automatic logic [CP_W-1:0] rand_skin_cp();
      return CP_W'(21'h1F3FB + $urandom_range(0, 4));
   endfunction

   // Hangul syllable chaining: which kind may follow the cluster's tail
   function automatic bit hk_follows(input logic [HK_W-1:0] tail,
                                     input logic [HK_W-1:0] cur);
      bit ok;
      ok = 1'b0;
      case (tail)
         gcw_pkg::HK_L:
            ok = (cur == gcw_pkg::HK_L) || (cur == gcw_pkg::HK_V) ||
                 (cur == gcw_pkg::HK_LV) || (cur == gcw_pkg::HK_LVT);
         gcw_pkg::HK_V, gcw_pkg::HK_LV:
            ok = (cur == gcw_pkg::HK_V) || (cur == gcw_pkg::HK_T);
         gcw_pkg::HK_T, gcw_pkg::HK_LVT:
            ok = (cur == gcw_pkg::HK_T);
         default:
            ok = 1'b0;
      endcase
      return ok;
   endfunction

   // Advance the cluster state by one codepoint and return the cell it yields
   task automatic advance_cluster(input gcw_pkg::item_type w,
                                  output cell_result_type c);
      bit                     joins;
      logic signed [WC_W-1:0] code;
      logic [CNT_W-1:0]       slot;
      joins = 1'b0;
      code  = gcw_pkg::WC_JOIN;
      if (cl_len != 0 && !w.restart) begin
         case (w.base_class)
            gcw_pkg::CLS_EMOJI_MOD: begin
               if (!w.is_skin_tone || cl_prev_class == gcw_pkg::CLS_PICTO) begin
                  if (cl_flags == gcw_pkg::FLAG_NONE)
                     code = gcw_pkg::WC_WIDEN;
                  cl_flags = gcw_pkg::FLAG_ALL;
                  joins    = 1'b1;
               end
            end
            gcw_pkg::CLS_TEXT_MOD: begin
               cl_picto = 1'b0;
               cl_flags = cl_flags & gcw_pkg::FLAG_WIDE;
               joins    = 1'b1;
            end
            gcw_pkg::CLS_PICTO:
               joins = cl_picto && cl_after_zwj;
            gcw_pkg::CLS_REGIONAL:
               joins = (cl_prev_class == gcw_pkg::CLS_REGIONAL) && (cl_len == 1);
            gcw_pkg::CLS_HANGUL:
               joins = hk_follows(cl_tail_hk, w.hangul_kind);
            gcw_pkg::CLS_COMBINING:
               joins = 1'b1;
            default:
               joins = 1'b0;
         endcase
      end
      if (joins) begin
         slot = cl_len;
         // saturated cluster keeps its count and its Hangul tail
         if (cl_len < CLUSTER_CAP) begin
            cl_tail_hk = w.hangul_kind;
            cl_len     = cl_len + 1'b1;
         end
      end else begin
         slot       = '0;
         cl_picto   = (w.base_class == gcw_pkg::CLS_PICTO);
         cl_flags   = {w.double_width, w.emoji_char};
         cl_len     = CNT_W'(1);
         cl_tail_hk = w.hangul_kind;
         code       = (cl_flags != gcw_pkg::FLAG_NONE) ? gcw_pkg::WC_WIDE
                                                       : gcw_pkg::WC_NARROW;
      end
      cl_after_zwj  = w.is_zwj;
      cl_prev_class = w.base_class;
      c = mk_cell(code, cl_flags[0], cl_flags[1], slot, w.codepoint, cl_len);
   endtask

   // Offer one word, hold it until taken, then queue its expected cell
   task automatic send_word(input gcw_pkg::item_type w, input bit typed = 1'b0,
                            input cell_result_type want = '0);
      cell_result_type c;
      if (!calm_tail && $urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end
      @(negedge clock);
      req_codepoint    = w.codepoint;
      req_base_class   = w.base_class;
      req_is_zwj       = w.is_zwj;
      req_is_skin_tone = w.is_skin_tone;
      req_hangul_kind  = w.hangul_kind;
      req_emoji_char   = w.emoji_char;
      req_double_width = w.double_width;
      req_restart      = w.restart;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      advance_cluster(w, c);
      pending_cells.push_back(typed ? want : c);
      words_sent++;
      if (words_sent % 64 == 0)
         case ($urandom_range(0, 2))
            0:       req_idle_pct = 0;
            1:       req_idle_pct = 10;
            default: req_idle_pct = 35;
         endcase
   endtask

   // result side: random stall bursts, one long hold-off to fill the pipe
   initial begin : rsp_side
      int burst;
      int pct;
      int tick;
      bit pressured;
      burst     = 0;
      pct       = 10;
      tick      = 0;
      pressured = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 100 == 0)
            case ($urandom_range(0, 2))
               0:       pct = 0;
               1:       pct = 10;
               default: pct = 35;
            endcase
         if (!pressured && words_sent >= PRESSURE_AT) begin
            pressured = 1'b1;
            rsp_stall = 1'b1;
            repeat (PRESSURE_LEN) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (calm_tail) begin
            rsp_stall = 1'b0;
         end else if (burst > 0) begin
            burst--;
         end else if ($urandom_range(0, 99) < pct) begin
            rsp_stall = 1'b1;
            burst     = $urandom_range(0, 15);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.width_code = rsp_width_code;
         seen.emoji      = rsp_cluster_emoji;
         seen.wide       = rsp_cluster_wide;
         seen.slot       = rsp_store_slot;
         seen.cp         = rsp_stored_codepoint;
         seen.len        = rsp_cluster_length;
         if (pending_cells.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("result word with none expected: cp %h", seen.cp);
         end else begin
            due = pending_cells.pop_front();
            if (seen.width_code !== due.width_code || seen.emoji !== due.emoji ||
                seen.wide !== due.wide || seen.slot !== due.slot ||
                seen.cp !== due.cp || seen.len !== due.len) begin
               err_count++;
               if (err_count <= 10)
                  $display("mismatch: expected code %0d emoji %b wide %b slot %0d",
                           due.width_code, due.emoji, due.wide, due.slot,
                           " cp %h len %0d", due.cp, due.len,
                           ", got code %0d emoji %b wide %b slot %0d",
                           seen.width_code, seen.emoji, seen.wide, seen.slot,
                           " cp %h len %0d", seen.cp, seen.len);
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      dir_row_type     dir_rows [DIR_ROWS];
      int              n;
      logic            rst;
      bit              long_run;
      logic [HK_W-1:0] hk;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_codepoint    = '0;
      req_base_class   = gcw_pkg::CLS_OTHER;
      req_is_zwj       = 1'b0;
      req_is_skin_tone = 1'b0;
      req_hangul_kind  = gcw_pkg::HK_NONE;
      req_emoji_char   = 1'b0;
      req_double_width = 1'b0;
      req_restart      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      dir_rows = '{
         // plain letter after reset, then a combining mark
         {mk_word(21'h00041, gcw_pkg::CLS_OTHER, 0, 0, gcw_pkg::HK_NONE, 0, 0, 0),
          1'b1, mk_cell(gcw_pkg::WC_NARROW, 0, 0, 0, 21'h00041, 1)},
         {mk_word(21'h00301, gcw_pkg::CLS_COMBINING, 0, 0, gcw_pkg::HK_NONE, 0, 0, 0),
          1'b1, mk_cell(gcw_pkg::WC_JOIN, 0, 0, 1, 21'h00301, 2)},
         // emoji presentation on a flagless cluster widens the cell
         {mk_word(21'h0FE0F, gcw_pkg::CLS_EMOJI_MOD, 0, 0, gcw_pkg::HK_NONE, 0, 0, 0),
          1'b1, mk_cell(gcw_pkg::WC_WIDEN, 1, 1, 2, 21'h0FE0F, 3)},
         {mk_word(21'h0FE0E, gcw_pkg::CLS_TEXT_MOD, 0, 0, gcw_pkg::HK_NONE, 0, 0, 0),
          1'b1, mk_cell(gcw_pkg::WC_JOIN, 0, 1, 3, 21'h0FE0E, 4)},
         {mk_word(21'h1F468, gcw_pkg::CLS_PICTO, 0, 0, gcw_pkg::HK_NONE, 1, 1, 0),
          1'b1, mk_cell(gcw_pkg::WC_WIDE, 1, 1, 0, 21'h1F468, 1)},
         {mk_word(21'h1F3FB, gcw_pkg::CLS_EMOJI_MOD, 0, 1, gcw_pkg::HK_NONE, 1, 1, 0),
          1'b1, mk_cell(gcw_pkg::WC_JOIN, 1, 1, 1, 21'h1F3FB, 2)},
         // ZWJ pictograph chain
         {mk_word(21'h0200D, gcw_pkg::CLS_COMBINING, 1, 0, gcw_pkg::HK_NONE, 0, 0, 0),
          1'b0, NO_CELL},
         {mk_word(21'h1F4BB, gcw_pkg::CLS_PICTO, 0, 0, gcw_pkg::HK_NONE, 1, 1, 0),
          1'b0, NO_CELL},
         // skin tone with no pictograph before it
         {mk_word(21'h00061, gcw_pkg::CLS_OTHER, 0, 0, gcw_pkg::HK_NONE, 0, 0, 0),
          1'b0, NO_CELL},
         {mk_word(21'h1F3FD, gcw_pkg::CLS_EMOJI_MOD, 0, 1, gcw_pkg::HK_NONE, 1, 1, 0),
          1'b0, NO_CELL},
         // regional indicators pair up, the third starts over
         {mk_word(21'h1F1FA, gcw_pkg::CLS_REGIONAL, 0, 0, gcw_pkg::HK_NONE, 1, 1, 0),
          1'b0, NO_CELL},
         {mk_word(21'h1F1F8, gcw_pkg::CLS_REGIONAL, 0, 0, gcw_pkg::HK_NONE, 1, 1, 0),
          1'b0, NO_CELL},
         {mk_word(21'h1F1EF, gcw_pkg::CLS_REGIONAL, 0, 0, gcw_pkg::HK_NONE, 1, 1, 0),
          1'b0, NO_CELL},
         // Hangul L V T, LV T, LVT then L
         {mk_word(21'h01100, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_L, 0, 1, 0),
          1'b0, NO_CELL},
         {mk_word(21'h01161, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_V, 0, 0, 0),
          1'b0, NO_CELL},
         {mk_word(21'h011A8, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_T, 0, 0, 0),
          1'b0, NO_CELL},
         {mk_word(21'h0AC00, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_LV, 0, 1, 0),
          1'b0, NO_CELL},
         {mk_word(21'h011A8, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_T, 0, 0, 0),
          1'b0, NO_CELL},
         {mk_word(21'h0AC01, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_LVT, 0, 1, 0),
          1'b0, NO_CELL},
         {mk_word(21'h01100, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_L, 0, 1, 0),
          1'b0, NO_CELL},
         // undefined Hangul kinds act as none
         {mk_word(21'h01101, gcw_pkg::CLS_HANGUL, 0, 0, HK_UNUSED_6, 0, 1, 0),
          1'b0, NO_CELL},
         {mk_word(21'h011A9, gcw_pkg::CLS_HANGUL, 0, 0, gcw_pkg::HK_T, 0, 0, 0),
          1'b0, NO_CELL},
         {mk_word(21'h00000, CLS_UNUSED, 0, 0, HK_UNUSED_7, 0, 0, 0),
          1'b0, NO_CELL},
         // restart forces a new cluster, top codepoints
         {mk_word(21'h10FFFF, gcw_pkg::CLS_COMBINING, 1, 1, gcw_pkg::HK_LVT, 1, 1, 1),
          1'b1, mk_cell(gcw_pkg::WC_WIDE, 1, 1, 0, 21'h10FFFF, 1)},
         {mk_word(21'h1FFFFF, gcw_pkg::CLS_COMBINING, 0, 0, gcw_pkg::HK_NONE, 0, 0, 0),
          1'b0, NO_CELL}
      };

      foreach (dir_rows[i])
         send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

      while (words_sent < DIR_ROWS + RANDOM_WORDS) begin
         if (words_sent >= DIR_ROWS + RANDOM_WORDS - CALM_WORDS)
            calm_tail = 1'b1;
         rst = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 4))
               send_word(gcw_pkg::item_type'($urandom));
            2, 3: begin
               // pictograph, optional skin tone, ZWJ links
               send_word(mk_word(rand_picto_cp(), gcw_pkg::CLS_PICTO,
                                 0, 0, gcw_pkg::HK_NONE, 1, 1, rst));
               if ($urandom_range(0, 1))
                  send_word(mk_word(rand_skin_cp(), gcw_pkg::CLS_EMOJI_MOD,
                                    0, 1, gcw_pkg::HK_NONE, 1, 1, 0));
               repeat ($urandom_range(0, 3)) begin
                  send_word(mk_word(21'h0200D, gcw_pkg::CLS_COMBINING, 1, 0,
                                    gcw_pkg::HK_NONE, 0, 0, 0));
                  send_word(mk_word(rand_picto_cp(), gcw_pkg::CLS_PICTO,
                                    0, 0, gcw_pkg::HK_NONE, rand_bit(),
                                    rand_bit(), 0));
                  case ($urandom_range(0, 3))
                     0: send_word(mk_word(21'h0FE0F, gcw_pkg::CLS_EMOJI_MOD, 0, 0,
                                          gcw_pkg::HK_NONE, 0, 0, 0));
                     1: send_word(mk_word(rand_skin_cp(), gcw_pkg::CLS_EMOJI_MOD,
                                          0, 1, gcw_pkg::HK_NONE, 1, 1, 0));
                     default: ;
                  endcase
               end
            end
            4: begin
               // Hangul jamo; a long run of L can saturate the cluster
               long_run = ($urandom_range(0, 5) == 0);
               n = long_run ? $urandom_range(15, 20) : $urandom_range(2, 6);
               repeat (n) begin
                  if (long_run)
                     hk = gcw_pkg::HK_L;
                  else if ($urandom_range(0, 7) == 0)
                     hk = HK_W'($urandom_range(0, 7));
                  else
                     hk = HK_W'($urandom_range(1, 5));
                  send_word(mk_word(CP_W'(21'h0AC00 + $urandom_range(0, 11171)),
                                    gcw_pkg::CLS_HANGUL, 0, 0, hk, 0, 1, 0));
               end
               if (long_run)
                  send_word(mk_word(21'h01161, gcw_pkg::CLS_HANGUL, 0, 0,
                                    gcw_pkg::HK_V, 0, 0, 0));
            end
            5: repeat ($urandom_range(1, 4))
               send_word(mk_word(CP_W'(21'h1F1E6 + $urandom_range(0, 25)),
                                 gcw_pkg::CLS_REGIONAL, 0, 0, gcw_pkg::HK_NONE,
                                 1, 1, 0));
            6, 7: begin
               // base plus combining marks, sometimes past the cluster cap
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 22)
                                               : $urandom_range(1, 4);
               send_word(mk_word(CP_W'($urandom_range(21'h00020, 21'h0FFFF)),
                                 rand_bit() ? gcw_pkg::CLS_OTHER : gcw_pkg::CLS_PICTO,
                                 0, 0, gcw_pkg::HK_NONE, rand_bit(), rand_bit(),
                                 rst));
               repeat (n)
                  send_word(mk_word(CP_W'(21'h00300 + $urandom_range(0, 111)),
                                    gcw_pkg::CLS_COMBINING,
                                    $urandom_range(0, 5) == 0, 0,
                                    gcw_pkg::HK_NONE, 0, 0, 0));
            end
            8: begin
               // text presentation drops the pictograph chain
               send_word(mk_word(rand_picto_cp(), gcw_pkg::CLS_PICTO,
                                 0, 0, gcw_pkg::HK_NONE, 1, 1, rst));
               send_word(mk_word(21'h0FE0E, gcw_pkg::CLS_TEXT_MOD, 0, 0,
                                 gcw_pkg::HK_NONE, 0, 0, 0));
               send_word(mk_word(21'h0200D, gcw_pkg::CLS_COMBINING, 1, 0,
                                 gcw_pkg::HK_NONE, 0, 0, 0));
               send_word(mk_word(rand_picto_cp(), gcw_pkg::CLS_PICTO,
                                 0, 0, gcw_pkg::HK_NONE, 1, 1, 0));
            end
            default: begin
               send_word(mk_word(CP_W'(21'h00020 + $urandom_range(0, 94)),
                                 gcw_pkg::CLS_OTHER, 0, 0, gcw_pkg::HK_NONE, 0,
                                 rand_bit(), rst));
               send_word(mk_word(21'h0FE0F, gcw_pkg::CLS_EMOJI_MOD, 0, 0,
                                 gcw_pkg::HK_NONE, 0, 0, 0));
               send_word(mk_word(rand_skin_cp(), gcw_pkg::CLS_EMOJI_MOD,
                                 0, 1, gcw_pkg::HK_NONE, 1, 1, 0));
            end
         endcase
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0 && pending_cells.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
